// ===== hdl/bwed_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwed_pkg
// Shared types and constants for the bit weighted edit distance unit.
// ----------------------------------------------------------------------------
package bwed_pkg;

    // Request kinds
    localparam logic REQ_REF  = 1'b0;
    localparam logic REQ_RCVD = 1'b1;

    // Limits of the fixed-width counters and result fields
    localparam logic [15:0] RCVD_MAX = 16'hFFFF;
    localparam logic [31:0] ERR_MAX  = 32'h0000_FFFF;

    // One request item
    typedef struct packed {
        logic       req_type;
        logic [7:0] byte_value;
        logic       is_last;
    } req_item_t;

    // One result item
    typedef struct packed {
        logic [15:0] edit_dist;
        logic [10:0] ref_length;
        logic        saturated;
    } res_item_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_ROW0,
        ST_RUN,
        ST_FINISH
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic store_ref;
        logic init_start;
        logic init_step;
        logic cmp_start;
        logic row0;
        logic run_step;
        logic emit;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic at_end;
        logic out_busy;
    } status_t;

    // Number of differing bits between two bytes
    function automatic logic [3:0] bit_diff(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] x;
        logic [3:0] n;
        x = a ^ b;
        n = 4'd0;
        for (int k = 0; k < 8; k++) begin
            n = n + {3'b000, x[k]};
        end
        return n;
    endfunction

endpackage

// ===== hdl/bit_weighted_edit_distance_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_weighted_edit_distance_unit
// Edit distance between a stored reference string and a received string,
// with unit insertion and deletion cost and bit-count substitution cost.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake              | Payload
//  req     | in        | req_valid / req_ready  | req_item (type, byte, last)
//  res     | out       | res_valid / res_ready  | res_item (dist, length, sat)
//
//  A reference byte is stored as it is accepted; the last one then sets the
//  row to 0..n (n = stored reference length), one row entry per cycle.
//  A received byte sweeps the row: the row memory port updates one entry
//  per cycle. A last received byte then loads the result into the output
//  register, and stalls only while that register is still full.
//  Reset clears all control state; the reference store and row need none.
// ----------------------------------------------------------------------------
module bit_weighted_edit_distance_unit #(
    parameter int MAX_REF    = 1024,
    parameter int DIST_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  bwed_pkg::req_item_t req_item,
    output logic                res_valid,
    input  logic                res_ready,
    output bwed_pkg::res_item_t res_item
);
    import bwed_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer
    bwed_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req_item.req_type),
        .req_last  (req_item.is_last),
        .status    (status),
        .cmd       (cmd)
    );

    // Stores, cell update and result register
    bwed_datapath #(
        .MAX_REF    (MAX_REF),
        .DIST_WIDTH (DIST_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_value (req_item.byte_value),
        .cmd        (cmd),
        .status     (status),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res_item   (res_item)
    );

endmodule

// ===== hdl/bwed_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwed_ctrl
// Sequencer: accepts requests, runs the row initialisation and row update
// sweeps, and issues the result.
// ----------------------------------------------------------------------------
module bwed_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic              req_type,
    input  logic              req_last,
    input  bwed_pkg::status_t status,
    output bwed_pkg::cmd_t    cmd
);
    import bwed_pkg::*;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;
    logic   last_reg,  last_next;

    // Hold state, phase and last mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            last_reg  <= last_next;
        end
    end

    // Decide next state and commands
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        last_next  = last_reg;
        req_ready  = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    if (!phase_reg)
                    begin
                        // Loading: take reference bytes, drop received ones
                        if (req_type == REQ_REF)
                        begin
                            cmd.store_ref = 1'b1;
                            if (req_last)
                            begin
                                cmd.init_start = 1'b1;
                                state_next     = ST_INIT;
                            end
                        end
                    end
                    else
                    begin
                        // Comparing: take received bytes, drop reference ones
                        if (req_type == REQ_RCVD)
                        begin
                            cmd.cmp_start = 1'b1;
                            last_next     = req_last;
                            state_next    = ST_ROW0;
                        end
                    end
                end
            end
            ST_INIT:
            begin
                cmd.init_step = 1'b1;
                if (status.at_end)
                begin
                    phase_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_ROW0:
            begin
                cmd.row0   = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                cmd.run_step = 1'b1;
                if (status.at_end)
                begin
                    state_next = last_reg ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                // Wait for the result register to drain
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    phase_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/bwed_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwed_datapath
// Reference store, DP row memory, one-cell update unit and result register.
// ----------------------------------------------------------------------------
module bwed_datapath #(
    parameter int MAX_REF    = 1024,
    parameter int DIST_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          byte_value,
    input  bwed_pkg::cmd_t      cmd,
    output bwed_pkg::status_t   status,
    output logic                res_valid,
    input  logic                res_ready,
    output bwed_pkg::res_item_t res_item
);
    import bwed_pkg::*;

    localparam int IW  = $clog2(MAX_REF + 1);
    localparam int RAW = (MAX_REF > 1) ? $clog2(MAX_REF) : 1;
    localparam int SW  = DIST_WIDTH + 1;
    localparam logic [DIST_WIDTH-1:0] DIST_LIMIT = '1;
    localparam logic [31:0] LIMIT32 = 32'(DIST_LIMIT);

    // Memories
    logic [7:0]            ref_mem [0:MAX_REF-1];
    logic [DIST_WIDTH-1:0] row_mem [0:MAX_REF];

    // Registers
    logic [IW-1:0]         ref_count_reg, ref_count_next;
    logic [15:0]           rcvd_reg,      rcvd_next;
    logic                  sat_reg,       sat_next;
    logic [IW-1:0]         idx_reg,       idx_next;
    logic [7:0]            byte_reg,      byte_next;
    logic [DIST_WIDTH-1:0] diag_reg,      diag_next;
    logic [DIST_WIDTH-1:0] left_reg,      left_next;
    logic                  out_valid_reg, out_valid_next;
    res_item_t             out_reg,       out_next;
    logic [DIST_WIDTH-1:0] row_rd_reg;
    logic [7:0]            ref_rd_reg;

    // Memory port controls
    logic                  ref_we;
    logic                  row_we;
    logic [IW-1:0]         row_wa;
    logic [DIST_WIDTH-1:0] row_wd;
    logic                  row_re;
    logic [IW-1:0]         row_ra;
    logic                  ref_re;
    logic [RAW-1:0]        ref_ra;

    // Cell update terms
    logic                  at_end;
    logic                  idx_sat;
    logic                  rcvd_sat;
    logic [SW-1:0]         sub_cost;
    logic [SW-1:0]         ins_cost;
    logic [SW-1:0]         del_cost;
    logic [SW-1:0]         best;
    logic                  best_sat;
    logic [DIST_WIDTH-1:0] best_clamped;
    logic [DIST_WIDTH-1:0] rcvd_clamped;
    logic [DIST_WIDTH-1:0] idx_clamped;
    logic [31:0]           dist32;
    logic [31:0]           count32;
    logic                  err_sat;

    assign at_end = (idx_reg == ref_count_reg);

    // Clamp the column index and the received count to the row limit
    assign idx_sat      = (32'(idx_reg) >= LIMIT32);
    assign idx_clamped  = idx_sat ? DIST_LIMIT : DIST_WIDTH'(idx_reg);
    assign rcvd_sat     = (32'(rcvd_reg) >= LIMIT32);
    assign rcvd_clamped = rcvd_sat ? DIST_LIMIT : DIST_WIDTH'(rcvd_reg);

    // One DP cell: minimum of substitution, insertion and deletion
    always_comb
    begin
        sub_cost = SW'(diag_reg) + SW'(bit_diff(ref_rd_reg, byte_reg));
        ins_cost = SW'(left_reg) + SW'(1);
        del_cost = SW'(row_rd_reg) + SW'(1);
        best     = sub_cost;
        if (ins_cost < best)
        begin
            best = ins_cost;
        end
        if (del_cost < best)
        begin
            best = del_cost;
        end
        best_sat     = (best >= SW'(DIST_LIMIT));
        best_clamped = best_sat ? DIST_LIMIT : best[DIST_WIDTH-1:0];
    end

    // Result fields
    assign dist32  = 32'(left_reg);
    assign err_sat = (dist32 > ERR_MAX);
    assign count32 = 32'(ref_count_reg);

    // Steer memory ports
    always_comb
    begin
        ref_we = cmd.store_ref && (ref_count_reg < IW'(MAX_REF));
        row_we = 1'b0;
        row_wa = idx_reg;
        row_wd = idx_clamped;
        row_re = 1'b0;
        row_ra = idx_reg + IW'(1);
        ref_re = 1'b0;
        ref_ra = idx_reg[RAW-1:0];
        if (cmd.init_step)
        begin
            row_we = 1'b1;
        end
        if (cmd.cmp_start)
        begin
            row_re = 1'b1;
            row_ra = '0;
        end
        if (cmd.row0)
        begin
            row_we = 1'b1;
            row_wa = '0;
            row_wd = rcvd_clamped;
            row_re = 1'b1;
            ref_re = 1'b1;
        end
        if (cmd.run_step)
        begin
            row_we = 1'b1;
            row_wd = best_clamped;
            row_re = !at_end;
            ref_re = !at_end;
        end
    end

    // Work out next register values
    always_comb
    begin
        ref_count_next = ref_count_reg;
        rcvd_next      = rcvd_reg;
        sat_next       = sat_reg;
        idx_next       = idx_reg;
        byte_next      = byte_reg;
        diag_next      = diag_reg;
        left_next      = left_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (ref_we)
        begin
            ref_count_next = ref_count_reg + IW'(1);
        end
        if (cmd.init_start)
        begin
            idx_next  = '0;
            sat_next  = 1'b0;
            rcvd_next = '0;
        end
        if (cmd.init_step)
        begin
            idx_next = idx_reg + IW'(1);
            sat_next = sat_reg | idx_sat;
        end
        if (cmd.cmp_start)
        begin
            byte_next = byte_value;
            idx_next  = '0;
            if (rcvd_reg != RCVD_MAX)
            begin
                rcvd_next = rcvd_reg + 16'd1;
            end
        end
        if (cmd.row0)
        begin
            diag_next = row_rd_reg;
            left_next = rcvd_clamped;
            sat_next  = sat_reg | rcvd_sat;
            idx_next  = idx_reg + IW'(1);
        end
        if (cmd.run_step)
        begin
            diag_next = row_rd_reg;
            left_next = best_clamped;
            sat_next  = sat_reg | best_sat;
            idx_next  = idx_reg + IW'(1);
        end

        // Drain the result register, then load a new result
        if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next      = 1'b1;
            out_next.edit_dist  = err_sat ? ERR_MAX[15:0] : dist32[15:0];
            out_next.ref_length = count32[10:0];
            out_next.saturated  = sat_reg | err_sat;
            ref_count_next      = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_count_reg <= '0;
            rcvd_reg      <= '0;
            sat_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ref_count_reg <= ref_count_next;
            rcvd_reg      <= rcvd_next;
            sat_reg       <= sat_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        diag_reg <= diag_next;
        left_reg <= left_next;
        out_reg  <= out_next;
    end

    // Reference store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (ref_we)
        begin
            ref_mem[ref_count_reg[RAW-1:0]] <= byte_value;
        end
        if (ref_re)
        begin
            ref_rd_reg <= ref_mem[ref_ra];
        end
    end

    // DP row memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_wa] <= row_wd;
        end
        if (row_re)
        begin
            row_rd_reg <= row_mem[row_ra];
        end
    end

    assign status.at_end   = at_end;
    assign status.out_busy = out_valid_reg;
    assign res_valid       = out_valid_reg;
    assign res_item        = out_reg;

endmodule

// ===== bench/tb_bit_weighted_edit_distance_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bit_weighted_edit_distance_unit
// Drives reference and received byte strings into the edit distance unit and
// checks each result against a behavioural predictor or the expected result
// of a directed row. A directed table covers corner cases (ignored requests,
// full mismatch, pure deletions and insertions); mutated random strings
// follow, with random gaps on requests and random back-pressure on results.
// ----------------------------------------------------------------------------
module tb_bit_weighted_edit_distance_unit;

    import bwed_pkg::*;

    localparam int          MAX_REF        = 1024;
    localparam int          DIST_WIDTH     = 16;
    localparam int unsigned DIST_MAX       = (1 << DIST_WIDTH) - 1;
    localparam int          RANDOM_ITEMS   = 555;
    localparam int          CALM_ITEMS     = 500;
    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          END_DRAIN      = 2200;
    localparam int          DIRECTED_ROWS  = 19;

    localparam res_item_t NO_RESULT = '0;

    // One row of the directed table; is_last goes on the final copy only
    typedef struct packed {
        logic        kind;
        logic [7:0]  value;
        logic        last;
        logic [31:0] copies;
        logic        typed;
        res_item_t   want;
    } stim_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_ready;
    req_item_t req_item  = '0;
    logic      res_valid;
    logic      res_ready = 1'b1;
    res_item_t res_item;

    // Predictor state
    logic [7:0]  stored_ref [MAX_REF];
    int unsigned dist_row [MAX_REF + 1];
    int unsigned ref_len   = 0;
    int unsigned rcvd_len  = 0;
    bit          comparing = 1'b0;
    bit          row_sat   = 1'b0;

    res_item_t   pending_distances [$];
    res_item_t   head_distance;
    int          items_sent    = 0;
    int          failures      = 0;
    int          stall_cycles  = 0;
    bit          idling_on     = 1'b1;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // received bytes while loading are dropped
        '{REQ_RCVD, 8'h55, 1'b1, 32'd1,     1'b0, NO_RESULT},
        '{REQ_RCVD, 8'hAA, 1'b0, 32'd1,     1'b0, NO_RESULT},
        // two byte reference, then a reference byte while comparing
        '{REQ_REF,  8'h00, 1'b0, 32'd1,     1'b0, NO_RESULT},
        '{REQ_REF,  8'hFF, 1'b1, 32'd1,     1'b0, NO_RESULT},
        '{REQ_REF,  8'h12, 1'b1, 32'd1,     1'b0, NO_RESULT},
        '{REQ_RCVD, 8'h00, 1'b0, 32'd1,     1'b0, NO_RESULT},
        '{REQ_RCVD, 8'hFF, 1'b1, 32'd1,     1'b1, '{16'd0, 11'd2, 1'b0}},
        // all bits differ: delete plus insert beats substitution
        '{REQ_REF,  8'hA5, 1'b1, 32'd1,     1'b0, NO_RESULT},
        '{REQ_RCVD, 8'h5A, 1'b1, 32'd1,     1'b1, '{16'd2, 11'd1, 1'b0}},
        // deletions
        '{REQ_REF,  8'h00, 1'b1, 32'd3,     1'b0, NO_RESULT},
        '{REQ_RCVD, 8'h01, 1'b1, 32'd1,     1'b1, '{16'd3, 11'd3, 1'b0}},
        // insertions
        '{REQ_REF,  8'h80, 1'b1, 32'd1,     1'b0, NO_RESULT},
        '{REQ_RCVD, 8'h80, 1'b1, 32'd4,     1'b1, '{16'd3, 11'd1, 1'b0}},
        // single bit substitution
        '{REQ_REF,  8'h0F, 1'b1, 32'd1,     1'b0, NO_RESULT},
        '{REQ_RCVD, 8'h07, 1'b1, 32'd1,     1'b1, '{16'd1, 11'd1, 1'b0}},
        // three byte reference with a repeated byte
        '{REQ_REF,  8'h7E, 1'b0, 32'd2,     1'b0, NO_RESULT},
        '{REQ_REF,  8'h81, 1'b1, 32'd1,     1'b0, NO_RESULT},
        '{REQ_RCVD, 8'h81, 1'b0, 32'd1,     1'b0, NO_RESULT},
        '{REQ_RCVD, 8'h00, 1'b1, 32'd1,     1'b0, NO_RESULT}
    };

    bit_weighted_edit_distance_unit #(
        .MAX_REF    (MAX_REF),
        .DIST_WIDTH (DIST_WIDTH)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_item  (req_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Clamp a row value to the distance limit, noting saturation
    function automatic int unsigned clamp_row(input int unsigned v);
        if (v >= DIST_MAX)
        begin
            row_sat = 1'b1;
            return DIST_MAX;
        end
        return v;
    endfunction

    // Advance the predicted row by one request; returns 1 when a result is due
    function automatic bit predict_distance(input req_item_t it, output res_item_t r);
        int unsigned diag;
        int unsigned top;
        int unsigned best;
        r = '0;
        if (!comparing)
        begin
            if (it.req_type == REQ_RCVD)
                return 1'b0;
            if (ref_len < MAX_REF)
            begin
                stored_ref[ref_len] = it.byte_value;
                ref_len++;
            end
            if (it.is_last)
            begin
                row_sat  = 1'b0;
                rcvd_len = 0;
                for (int i = 0; i <= ref_len; i++)
                    dist_row[i] = clamp_row(i);
                comparing = 1'b1;
            end
            return 1'b0;
        end
        if (it.req_type == REQ_REF)
            return 1'b0;
        if (rcvd_len < RCVD_MAX)
            rcvd_len++;
        diag        = dist_row[0];
        dist_row[0] = clamp_row(rcvd_len);
        for (int i = 1; i <= ref_len; i++)
        begin
            top  = dist_row[i];
            best = diag + $countones(stored_ref[i - 1] ^ it.byte_value);
            if (dist_row[i - 1] + 1 < best)
                best = dist_row[i - 1] + 1;
            if (top + 1 < best)
                best = top + 1;
            dist_row[i] = clamp_row(best);
            diag        = top;
        end
        if (!it.is_last)
            return 1'b0;
        r.edit_dist  = dist_row[ref_len][15:0];
        r.ref_length = ref_len[10:0];
        r.saturated  = row_sat;
        comparing    = 1'b0;
        ref_len      = 0;
        return 1'b1;
    endfunction

    // Present one request, hold until accepted, queue what it should produce.
    // Called and returns at a falling edge.
    task automatic drive_req(input req_item_t it, input bit use_typed,
                             input res_item_t typed_res);
        int        gap;
        bit        produced;
        res_item_t predicted;
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 14);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_item  <= it;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        produced = predict_distance(it, predicted);
        if (produced)
            pending_distances = {pending_distances, (use_typed ? typed_res : predicted)};
        @(negedge clk);
    endtask

    // Occasionally slip in a request that the current phase ignores
    task automatic maybe_noise(input logic kind);
        if ($urandom_range(0, 19) == 0)
            drive_req('{req_type: kind, byte_value: 8'($urandom_range(0, 255)),
                        is_last: 1'($urandom_range(0, 1))}, 1'b0, NO_RESULT);
    endtask

    // One random reference and a received string mutated from it
    task automatic run_random_sequence();
        logic [7:0] ref_str [$];
        logic [7:0] rcvd_str [$];
        int         ref_n;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            ref_n = $urandom_range(20, 120);
        else
            ref_n = $urandom_range(1, 10);
        for (int i = 0; i < ref_n; i++)
            ref_str = {ref_str, 8'($urandom_range(0, 255))};

        foreach (ref_str[i])
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                continue;
            if (pick == 1)
                rcvd_str = {rcvd_str, 8'($urandom_range(0, 255))};
            if (pick == 2)
                rcvd_str = {rcvd_str, 8'(ref_str[i] ^ (8'h01 << $urandom_range(0, 7)))};
            else if (pick == 3)
                rcvd_str = {rcvd_str, 8'(ref_str[i] ^ 8'($urandom_range(0, 255)))};
            else
                rcvd_str = {rcvd_str, ref_str[i]};
        end
        if (rcvd_str.size() == 0)
            rcvd_str = {rcvd_str, 8'($urandom_range(0, 255))};

        foreach (ref_str[i])
        begin
            maybe_noise(REQ_RCVD);
            drive_req('{req_type: REQ_REF, byte_value: ref_str[i],
                        is_last: (i == ref_n - 1)}, 1'b0, NO_RESULT);
        end
        foreach (rcvd_str[i])
        begin
            maybe_noise(REQ_REF);
            drive_req('{req_type: REQ_RCVD, byte_value: rcvd_str[i],
                        is_last: (i == rcvd_str.size() - 1)}, 1'b0, NO_RESULT);
        end
        items_sent += ref_n + rcvd_str.size();
    endtask

    // Result back-pressure in random bursts
    initial
    begin
        @(negedge clk);
        forever
        begin
            if (idling_on && $urandom_range(0, 2) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            res_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge clk);
        end
    end

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_distances.size() == 0)
            begin
                $error("unexpected result: edit_dist %0d ref_length %0d saturated %0d",
                       res_item.edit_dist, res_item.ref_length, res_item.saturated);
                failures++;
            end
            else
            begin
                head_distance = pending_distances.pop_front();
                if (res_item.edit_dist !== head_distance.edit_dist)
                begin
                    $error("edit_dist: expected %0d, got %0d",
                           head_distance.edit_dist, res_item.edit_dist);
                    failures++;
                end
                if (res_item.ref_length !== head_distance.ref_length)
                begin
                    $error("ref_length: expected %0d, got %0d",
                           head_distance.ref_length, res_item.ref_length);
                    failures++;
                end
                if (res_item.saturated !== head_distance.saturated)
                begin
                    $error("saturated: expected %0d, got %0d",
                           head_distance.saturated, res_item.saturated);
                    failures++;
                end
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (res_valid && res_ready))
                stall_cycles <= 0;
            else if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // Main stimulus
    initial
    begin
        stim_row_t row;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // walk the directed table
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            row = directed_rows[r];
            for (int c = 0; c < row.copies; c++)
                drive_req('{req_type: row.kind, byte_value: row.value,
                            is_last: row.last && (c == row.copies - 1)},
                          row.typed && (c == row.copies - 1), row.want);
        end

        // random strings, calm towards the end
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= CALM_ITEMS)
                idling_on = 1'b0;
            run_random_sequence();
        end
        req_valid <= 1'b0;

        // drain outstanding results, then allow for a stray one
        while (pending_distances.size() != 0)
            @(posedge clk);
        repeat (END_DRAIN) @(posedge clk);

        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/bwed_pkg.sv
hdl/bwed_ctrl.sv
hdl/bwed_datapath.sv
hdl/bit_weighted_edit_distance_unit.sv
bench/tb_bit_weighted_edit_distance_unit.sv
